// ----- hdl/tcav_pkg.sv -----
package tcav_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int LIMIT_WIDTH  = 15;
    localparam int CFG_WIDTH    = (SAMPLE_WIDTH > LIMIT_WIDTH) ? SAMPLE_WIDTH : LIMIT_WIDTH;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int LIM3_WIDTH   = LIMIT_WIDTH + 2;
    localparam int LIM3SQ_WIDTH = 2 * LIM3_WIDTH;

    localparam logic signed [SAMPLE_WIDTH-1:0] MIN_VALID_RST = SAMPLE_WIDTH'(0);
    localparam logic signed [SAMPLE_WIDTH-1:0] MAX_VALID_RST = SAMPLE_WIDTH'(7680);
    localparam logic [LIMIT_WIDTH-1:0]         LIMIT_RST     = LIMIT_WIDTH'(1280);

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_MIN_VALID = 2'd0,
        CFG_MAX_VALID = 2'd1,
        CFG_DEV_LIMIT = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SRC_AVG_ABC  = 3'd0,
        SRC_AVG_AB   = 3'd1,
        SRC_AVG_AC   = 3'd2,
        SRC_AVG_BC   = 3'd3,
        SRC_FALLBACK = 3'd4,
        SRC_SINGLE   = 3'd5,
        SRC_HELD     = 3'd6
    } t_source;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] min_valid;
        logic signed [SAMPLE_WIDTH-1:0] max_valid;
        logic [LIMIT_WIDTH-1:0]         dev_limit;
        logic [LIM3SQ_WIDTH-1:0]        lim3_sq;
    } t_cfg;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic [2:0]                     mask;
        logic [1:0]                     count;
        t_source                        source;
    } t_result;

    function automatic logic [SAMPLE_WIDTH-1:0] abs_diff(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [SAMPLE_WIDTH-1:0] y
    );
        logic signed [SAMPLE_WIDTH:0] d;
        logic signed [SAMPLE_WIDTH:0] m;
        d = $signed({x[SAMPLE_WIDTH-1], x}) - $signed({y[SAMPLE_WIDTH-1], y});
        m = -d;
        return d[SAMPLE_WIDTH] ? m[SAMPLE_WIDTH-1:0] : d[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] avg2(
        input logic signed [SAMPLE_WIDTH-1:0] x,
        input logic signed [SAMPLE_WIDTH-1:0] y
    );
        logic signed [SAMPLE_WIDTH:0] s;
        s = $signed({x[SAMPLE_WIDTH-1], x}) + $signed({y[SAMPLE_WIDTH-1], y});
        return s[SAMPLE_WIDTH:1];
    endfunction

endpackage

// ----- hdl/tcav_in_if.sv -----
interface tcav_in_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] sample_a;
    logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] sample_b;
    logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] sample_c;

    modport source (output valid, output sample_a, output sample_b, output sample_c,
                    input ready);
    modport sink   (input valid, input sample_a, input sample_b, input sample_c,
                    output ready);
endinterface

// ----- hdl/tcav_out_if.sv -----
interface tcav_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] voted_value;
    logic [2:0]                               valid_mask;
    logic [1:0]                               valid_count;
    logic [2:0]                               vote_source;

    modport source (output valid, output voted_value, output valid_mask,
                    output valid_count, output vote_source, input ready);
    modport sink   (input valid, input voted_value, input valid_mask,
                    input valid_count, input vote_source, output ready);
endinterface

// ----- hdl/tcav_cfg.sv -----
module tcav_cfg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [tcav_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_idx,
    input  logic [tcav_pkg::CFG_WIDTH-1:0]          i_cfg_data,
    output tcav_pkg::t_cfg                          o_cfg
);
    localparam int SW = tcav_pkg::SAMPLE_WIDTH;
    localparam int LW = tcav_pkg::LIMIT_WIDTH;
    localparam int L3 = tcav_pkg::LIM3_WIDTH;
    localparam logic [tcav_pkg::LIM3SQ_WIDTH-1:0] LIM3SQ_RST = tcav_pkg::LIM3SQ_WIDTH'(
        64'd9 * 64'(tcav_pkg::LIMIT_RST) * 64'(tcav_pkg::LIMIT_RST));

    logic signed [SW-1:0]                  r_min;
    logic signed [SW-1:0]                  r_max;
    logic [LW-1:0]                         r_limit;
    logic [tcav_pkg::LIM3SQ_WIDTH-1:0]     r_lim3_sq;
    logic [tcav_pkg::LIM3SQ_WIDTH-1:0]     n_lim3_sq;
    logic [L3-1:0]                         w_lim3;

    assign w_lim3    = {1'b0, i_cfg_data[LW-1:0], 1'b0} + {2'b00, i_cfg_data[LW-1:0]};
    assign n_lim3_sq = w_lim3 * w_lim3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min     <= tcav_pkg::MIN_VALID_RST;
            r_max     <= tcav_pkg::MAX_VALID_RST;
            r_limit   <= tcav_pkg::LIMIT_RST;
            r_lim3_sq <= LIM3SQ_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcav_pkg::CFG_MIN_VALID: r_min   <= i_cfg_data[SW-1:0];
                tcav_pkg::CFG_MAX_VALID: r_max   <= i_cfg_data[SW-1:0];
                tcav_pkg::CFG_DEV_LIMIT: begin
                    r_limit   <= i_cfg_data[LW-1:0];
                    r_lim3_sq <= n_lim3_sq;
                end
                default: ;
            endcase
        end
    end

    assign o_cfg.min_valid = r_min;
    assign o_cfg.max_valid = r_max;
    assign o_cfg.dev_limit = r_limit;
    assign o_cfg.lim3_sq   = r_lim3_sq;
endmodule

// ----- hdl/tcav_vote.sv -----
module tcav_vote (
    input  logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] i_a,
    input  logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] i_b,
    input  logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] i_c,
    input  tcav_pkg::t_cfg                           i_cfg,
    input  logic signed [tcav_pkg::SAMPLE_WIDTH-1:0] i_held,
    output tcav_pkg::t_result                        o_res
);
    localparam int SW = tcav_pkg::SAMPLE_WIDTH;
    localparam int LW = tcav_pkg::LIMIT_WIDTH;
    localparam int CW = (SW > LW + 2) ? SW : LW + 2;
    localparam int SQ = 2 * SW + 2;
    localparam int QW = (SQ > tcav_pkg::LIM3SQ_WIDTH) ? SQ : tcav_pkg::LIM3SQ_WIDTH;
    localparam int N  = SW + 2;
    localparam logic [N-1:0] OFFSET3 = N'(3 * (64'd1 << (SW - 1)));
    localparam logic [N-1:0] RECIP3  = N'(((64'd1 << (N + 1)) + 64'd2) / 64'd3);
    localparam logic [SW-1:0] HALF   = SW'(64'd1 << (SW - 1));

    logic [2:0]           w_mask;
    logic [1:0]           w_count;
    logic [SW-1:0]        w_dab, w_dac, w_dbc, w_dv;
    logic [CW-1:0]        w_lim2, w_lim3;
    logic                 w_ab_ok, w_ac_ok, w_bc_ok, w_v_ok, w_tri_ok;
    logic [2*SW-1:0]      w_sq_ab, w_sq_ac, w_sq_bc;
    logic [QW-1:0]        w_sq_sum;
    logic signed [N-1:0]  w_sum3;
    logic [N-1:0]         w_u3;
    logic [2*N-1:0]       w_prod3;
    logic [SW-1:0]        w_avg3;
    logic signed [SW-1:0] w_v0, w_v1;
    tcav_pkg::t_source    w_pair_src;

    assign w_mask[0] = (i_a > i_cfg.min_valid) && (i_a < i_cfg.max_valid);
    assign w_mask[1] = (i_b > i_cfg.min_valid) && (i_b < i_cfg.max_valid);
    assign w_mask[2] = (i_c > i_cfg.min_valid) && (i_c < i_cfg.max_valid);
    assign w_count   = {1'b0, w_mask[0]} + {1'b0, w_mask[1]} + {1'b0, w_mask[2]};

    assign w_dab = tcav_pkg::abs_diff(i_a, i_b);
    assign w_dac = tcav_pkg::abs_diff(i_a, i_c);
    assign w_dbc = tcav_pkg::abs_diff(i_b, i_c);

    assign w_lim2 = CW'({i_cfg.dev_limit, 1'b0});
    assign w_lim3 = CW'({i_cfg.dev_limit, 1'b0}) + CW'(i_cfg.dev_limit);

    assign w_ab_ok = CW'(w_dab) <= w_lim2;
    assign w_ac_ok = CW'(w_dac) <= w_lim2;
    assign w_bc_ok = CW'(w_dbc) <= w_lim2;

    assign w_sq_ab  = w_dab * w_dab;
    assign w_sq_ac  = w_dac * w_dac;
    assign w_sq_bc  = w_dbc * w_dbc;
    assign w_sq_sum = QW'(w_sq_ab) + QW'(w_sq_ac) + QW'(w_sq_bc);
    assign w_tri_ok = (CW'(w_dab) <= w_lim3) && (CW'(w_dac) <= w_lim3)
                   && (CW'(w_dbc) <= w_lim3) && (w_sq_sum <= QW'(i_cfg.lim3_sq));

    assign w_sum3  = N'(i_a) + N'(i_b) + N'(i_c);
    assign w_u3    = w_sum3 + OFFSET3;
    assign w_prod3 = w_u3 * RECIP3;
    assign w_avg3  = w_prod3[N+SW:N+1] - HALF;

    always_comb begin
        unique case (w_mask)
            3'b011: begin
                w_v0 = i_a;  w_v1 = i_b;  w_pair_src = tcav_pkg::SRC_AVG_AB;
            end
            3'b101: begin
                w_v0 = i_a;  w_v1 = i_c;  w_pair_src = tcav_pkg::SRC_AVG_AC;
            end
            default: begin
                w_v0 = i_b;  w_v1 = i_c;  w_pair_src = tcav_pkg::SRC_AVG_BC;
            end
        endcase
    end

    assign w_dv   = tcav_pkg::abs_diff(w_v0, w_v1);
    assign w_v_ok = CW'(w_dv) <= w_lim2;

    always_comb begin
        o_res.mask  = w_mask;
        o_res.count = w_count;
        case (w_count)
            2'd0: begin
                o_res.value  = i_held;
                o_res.source = tcav_pkg::SRC_HELD;
            end
            2'd1: begin
                o_res.value  = w_mask[0] ? i_a : (w_mask[1] ? i_b : i_c);
                o_res.source = tcav_pkg::SRC_SINGLE;
            end
            2'd2: begin
                if (w_v_ok) begin
                    o_res.value  = tcav_pkg::avg2(w_v0, w_v1);
                    o_res.source = w_pair_src;
                end else begin
                    o_res.value  = w_v0;
                    o_res.source = tcav_pkg::SRC_FALLBACK;
                end
            end
            default: begin
                if (w_tri_ok) begin
                    o_res.value  = w_avg3;
                    o_res.source = tcav_pkg::SRC_AVG_ABC;
                end else if (w_ab_ok) begin
                    o_res.value  = tcav_pkg::avg2(i_a, i_b);
                    o_res.source = tcav_pkg::SRC_AVG_AB;
                end else if (w_ac_ok) begin
                    o_res.value  = tcav_pkg::avg2(i_a, i_c);
                    o_res.source = tcav_pkg::SRC_AVG_AC;
                end else if (w_bc_ok) begin
                    o_res.value  = tcav_pkg::avg2(i_b, i_c);
                    o_res.source = tcav_pkg::SRC_AVG_BC;
                end else begin
                    o_res.value  = i_a;
                    o_res.source = tcav_pkg::SRC_FALLBACK;
                end
            end
        endcase
    end
endmodule

// ----- hdl/triple_channel_analog_voter.sv -----
// channel   dir  handshake      payload
// i_in      in   valid/ready    sample_a, sample_b, sample_c
// o_out     out  valid/ready    voted_value, valid_mask, valid_count, vote_source
// i_cfg_*   in   write enable   register index, write data
//
// Beats pass sample regs, vote, result reg; one beat per cycle unless o_out stalls.
// Throughput is set by the single vote pass between the sample and result registers.
// Synchronous active-low reset clears valids and the held value and loads config defaults.
// A stalled output holds the result; the sample stage still takes one more beat.
module triple_channel_analog_voter (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    tcav_in_if.sink                            i_in,
    tcav_out_if.source                         o_out,
    input  logic                               i_cfg_we,
    input  logic [tcav_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  logic [tcav_pkg::CFG_WIDTH-1:0]     i_cfg_data
);
    localparam int SW = tcav_pkg::SAMPLE_WIDTH;

    tcav_pkg::t_cfg    w_cfg;
    tcav_pkg::t_result w_res;
    tcav_pkg::t_result r_out;

    logic                 r_s1_vld;
    logic signed [SW-1:0] r_a, r_b, r_c;
    logic signed [SW-1:0] r_held;
    logic                 r_out_vld;
    logic                 w_s1_adv;
    logic                 w_in_acc;
    logic                 w_fire;

    tcav_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    tcav_vote u_vote (
        .i_a    (r_a),
        .i_b    (r_b),
        .i_c    (r_c),
        .i_cfg  (w_cfg),
        .i_held (r_held),
        .o_res  (w_res)
    );

    assign w_s1_adv   = !r_out_vld || o_out.ready;
    assign i_in.ready = !r_s1_vld || w_s1_adv;
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_fire     = r_s1_vld && w_s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_a <= i_in.sample_a;
            r_b <= i_in.sample_b;
            r_c <= i_in.sample_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_held    <= '0;
        end else begin
            if (w_fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (w_fire && w_res.count != 2'd0) begin
                r_held <= w_res.value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.voted_value = r_out.value;
    assign o_out.valid_mask  = r_out.mask;
    assign o_out.valid_count = r_out.count;
    assign o_out.vote_source = r_out.source;

    a_rise_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_s1_vld))
        else $error("result beat without a sample in flight");

    a_count_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out.count == 2'($countones(r_out.mask))))
        else $error("valid count disagrees with valid mask");

    a_held_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.source == tcav_pkg::SRC_HELD) |-> (r_out.count == 2'd0))
        else $error("held value chosen with valid channels");

    a_held_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res.count != 2'd0) |=> (r_held == r_out.value))
        else $error("held value not updated from result");
endmodule

// ----- sim/triple_channel_analog_voter_tb.sv -----
`timescale 1ns / 100ps

module triple_channel_analog_voter_tb;
    import tcav_pkg::*;

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SPARE_IDX = 2'd3;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam longint SAMPLE_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 <<< (SAMPLE_WIDTH - 1));

    class vote_tracker;
        longint  min_valid;
        longint  max_valid;
        longint  dev_limit;
        longint  held_value;
        t_result pending_votes[$];
        int      errors;
        int      accepted;
        int      checked;

        function new();
            min_valid  = MIN_VALID_RST;
            max_valid  = MAX_VALID_RST;
            dev_limit  = LIMIT_RST;
            held_value = 0;
            errors     = 0;
            accepted   = 0;
            checked    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
            case (idx)
                CFG_MIN_VALID: min_valid = t_sample'(data);
                CFG_MAX_VALID: max_valid = t_sample'(data);
                CFG_DEV_LIMIT: dev_limit = data[LIMIT_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function longint floor_div(longint s, longint d);
            longint q;
            q = s / d;
            if ((s % d) != 0 && s < 0)
                q--;
            return q;
        endfunction

        function longint gap(longint x, longint y);
            return (x > y) ? x - y : y - x;
        endfunction

        function bit pair_agrees(longint x, longint y);
            return gap(x, y) <= 2 * dev_limit;
        endfunction

        function bit triple_agrees(longint a, longint b, longint c);
            longint l3;
            longint dab;
            longint dac;
            longint dbc;
            l3  = 3 * dev_limit;
            dab = gap(a, b);
            dac = gap(a, c);
            dbc = gap(b, c);
            if (dab > l3 || dac > l3 || dbc > l3)
                return 0;
            return dab * dab + dac * dac + dbc * dbc <= l3 * l3;
        endfunction

        function void accept_samples(t_sample a, t_sample b, t_sample c);
            longint  s[3];
            longint  v[3];
            longint  vote;
            int      n;
            t_result want;
            s[0] = a;
            s[1] = b;
            s[2] = c;
            n = 0;
            want.mask = '0;
            for (int i = 0; i < 3; i++) begin
                if (s[i] > min_valid && s[i] < max_valid) begin
                    want.mask[i] = 1'b1;
                    v[n] = s[i];
                    n++;
                end
            end
            if (n == 0) begin
                vote = held_value;
                want.source = SRC_HELD;
            end else if (n == 1) begin
                vote = v[0];
                want.source = SRC_SINGLE;
            end else if (n == 2) begin
                if (pair_agrees(v[0], v[1])) begin
                    vote = floor_div(v[0] + v[1], 2);
                    want.source = (want.mask == 3'b011) ? SRC_AVG_AB :
                                  (want.mask == 3'b101) ? SRC_AVG_AC : SRC_AVG_BC;
                end else begin
                    vote = v[0];
                    want.source = SRC_FALLBACK;
                end
            end else if (triple_agrees(s[0], s[1], s[2])) begin
                vote = floor_div(s[0] + s[1] + s[2], 3);
                want.source = SRC_AVG_ABC;
            end else if (pair_agrees(s[0], s[1])) begin
                vote = floor_div(s[0] + s[1], 2);
                want.source = SRC_AVG_AB;
            end else if (pair_agrees(s[0], s[2])) begin
                vote = floor_div(s[0] + s[2], 2);
                want.source = SRC_AVG_AC;
            end else if (pair_agrees(s[1], s[2])) begin
                vote = floor_div(s[1] + s[2], 2);
                want.source = SRC_AVG_BC;
            end else begin
                vote = s[0];
                want.source = SRC_FALLBACK;
            end
            if (n != 0)
                held_value = vote;
            want.value = t_sample'(vote);
            want.count = 2'(n);
            pending_votes.push_back(want);
            accepted++;
        endfunction

        function void check_vote(t_result got);
            t_result want;
            if (pending_votes.size() == 0) begin
                $display("%0t: unexpected vote beat, value %0d", $time, got.value);
                errors++;
                return;
            end
            want = pending_votes.pop_front();
            checked++;
            if (got.value !== want.value) begin
                $display("%0t: voted_value expected %0d got %0d", $time, want.value, got.value);
                errors++;
            end
            if (got.mask !== want.mask) begin
                $display("%0t: valid_mask expected %b got %b", $time, want.mask, got.mask);
                errors++;
            end
            if (got.count !== want.count) begin
                $display("%0t: valid_count expected %0d got %0d", $time, want.count, got.count);
                errors++;
            end
            if (got.source !== want.source) begin
                $display("%0t: vote_source expected %0d got %0d", $time, want.source,
                         got.source);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0] i_cfg_idx;
    logic [CFG_WIDTH-1:0]     i_cfg_data;

    tcav_in_if  in_ch ();
    tcav_out_if out_ch ();

    triple_channel_analog_voter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    vote_tracker board = new();
    int send_idle_pct = 11;
    int recv_idle_pct = 71;
    bit hold_off_req  = 0;
    int settings_run  = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d votes outstanding", board.pending_votes.size());
        $display("simulation failed");
        $finish;
    end

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 0;
                out_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                board.accept_samples(in_ch.sample_a, in_ch.sample_b, in_ch.sample_c);
            if (out_ch.valid && out_ch.ready) begin
                got.value  = out_ch.voted_value;
                got.mask   = out_ch.valid_mask;
                got.count  = out_ch.valid_count;
                got.source = t_source'(out_ch.vote_source);
                board.check_vote(got);
            end
        end
    end

    task automatic send_item(t_sample a, t_sample b, t_sample c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.sample_a <= a;
        in_ch.sample_b <= b;
        in_ch.sample_c <= c;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (board.pending_votes.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic t_sample clamp(longint v);
        if (v > SAMPLE_MAX)
            return t_sample'(SAMPLE_MAX);
        if (v < SAMPLE_MIN)
            return t_sample'(SAMPLE_MIN);
        return t_sample'(v);
    endfunction

    task automatic random_samples(output t_sample a, output t_sample b, output t_sample c);
        int     kind;
        longint lo;
        longint hi;
        longint center;
        longint amp;
        longint ch[3];
        kind = $urandom_range(9);
        if (kind < 2) begin
            a = t_sample'($urandom());
            b = t_sample'($urandom());
            c = t_sample'($urandom());
        end else begin
            lo = (board.min_valid < board.max_valid) ? board.min_valid : board.max_valid;
            hi = (board.min_valid < board.max_valid) ? board.max_valid : board.min_valid;
            center = lo + $urandom_range(int'(hi - lo));
            case ($urandom_range(3))
                0: amp = board.dev_limit / 2 + 1;
                1: amp = board.dev_limit + 1;
                2: amp = 2 * board.dev_limit + 2;
                default: amp = 4 * board.dev_limit + 8;
            endcase
            for (int i = 0; i < 3; i++)
                ch[i] = (kind == 3) ? center
                                    : center + longint'($urandom_range(int'(2 * amp))) - amp;
            if (kind == 2) begin
                case ($urandom_range(3))
                    0: ch[$urandom_range(2)] = board.min_valid;
                    1: ch[$urandom_range(2)] = board.max_valid;
                    2: ch[$urandom_range(2)] = board.min_valid + 1;
                    default: ch[$urandom_range(2)] = board.max_valid - 1;
                endcase
            end
            a = clamp(ch[0]);
            b = clamp(ch[1]);
            c = clamp(ch[2]);
        end
    endtask

    task automatic run_setting(longint lo, longint hi, logic [CFG_WIDTH-1:0] limit, int n);
        t_sample a;
        t_sample b;
        t_sample c;
        drain();
        write_reg(CFG_MIN_VALID, CFG_WIDTH'(lo));
        write_reg(CFG_MAX_VALID, CFG_WIDTH'(hi));
        write_reg(CFG_DEV_LIMIT, limit);
        settings_run++;
        for (int k = 0; k < n; k++) begin
            if (send_idle_pct == 0 && recv_idle_pct == 0 && (k % 120) == 60)
                hold_off_req = 1;
            random_samples(a, b, c);
            send_item(a, b, c);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = '0;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.sample_a = '0;
        in_ch.sample_b = '0;
        in_ch.sample_c = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_item(-16'sd32768, 16'sd32767, 16'sd0);
        send_item(16'sd1000, 16'sd1000, 16'sd1000);
        send_item(16'sd1, 16'sd7679, 16'sd3000);
        send_item(16'sd1000, 16'sd3000, 16'sd5000);
        send_item(16'sd1000, 16'sd5000, 16'sd3000);
        send_item(16'sd1000, 16'sd4000, 16'sd6000);
        send_item(16'sd1000, 16'sd4800, 16'sd2900);
        send_item(16'sd1000, 16'sd4000, 16'sd2500);
        send_item(16'sd2000, 16'sd3000, -16'sd5);
        send_item(16'sd2000, 16'sd8000, 16'sd2001);
        send_item(16'sd0, 16'sd100, 16'sd101);
        send_item(16'sd7000, -16'sd1, 16'sd100);
        send_item(-16'sd32768, 16'sd32767, 16'sd5);
        send_item(-16'sd32768, 16'sd32767, 16'sd0);
        send_item(16'sd100, 16'sd2660, -16'sd1);
        send_item(16'sd100, 16'sd2661, -16'sd1);
        send_item(16'sd0, 16'sd7680, 16'sd32767);
        send_item(16'sd7679, 16'sd0, 16'sd7680);
        send_item(-16'sd1, -16'sd1, -16'sd1);

        run_setting(-2560, 7680, 16'd256, 200);
        run_setting(SAMPLE_MIN, SAMPLE_MAX, 16'hFFFF, 200);

        send_idle_pct = 71;
        recv_idle_pct = 11;
        run_setting(SAMPLE_MIN, SAMPLE_MAX, 16'd0, 200);
        drain();
        write_reg(CFG_SPARE_IDX, 16'h7FFF);
        run_setting(100, 101, 16'd1280, 40);
        run_setting(-100, 100, 16'd5, 250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_setting(0, 7680, 16'd1280, 300);
        drain();

        $display("voted %0d sample beats, checked %0d result beats", board.accepted,
                 board.checked);
        $display("over %0d window and limit settings plus reset defaults, with stalls",
                 settings_run);
        if (board.errors == 0 && board.pending_votes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
